// ----- src/ppd_pkg.sv -----
// Shared types and constants of the ping-pong delay block.
package ppd_pkg;

    localparam int CFG_DATA_W  = 18;
    localparam int CFG_INDEX_W = 3;

    localparam int DELAY_W = 18;
    localparam int FB_W    = 15;
    localparam int MIX_W   = 16;
    localparam int NOTE_W  = 3;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] CFG_DELAY_SAMPLES = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FEEDBACK_GAIN = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIX_GAIN      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_ENABLE   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BEAT_SAMPLES  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_NOTE_DIVISION = 3'd5;

    // Note division codes.
    localparam logic [NOTE_W-1:0] NOTE_QUARTER           = 3'd0;
    localparam logic [NOTE_W-1:0] NOTE_EIGHTH            = 3'd1;
    localparam logic [NOTE_W-1:0] NOTE_EIGHTH_TRIPLET    = 3'd2;
    localparam logic [NOTE_W-1:0] NOTE_SIXTEENTH         = 3'd3;
    localparam logic [NOTE_W-1:0] NOTE_SIXTEENTH_TRIPLET = 3'd4;

    // floor(x / 3) = (x * DIV3_MULT) >> DIV3_SHIFT for every 18-bit x.
    localparam int                 DIV3_MULT_W = 19;
    localparam logic [DIV3_MULT_W-1:0] DIV3_MULT = 19'd349526;
    localparam int                 DIV3_SHIFT  = 20;

    // Unity gain in Q1.15.
    localparam logic [MIX_W-1:0] Q15_ONE = 16'h8000;

    localparam int QUEUE_DEPTH = 4;
    localparam int OQ_DEPTH    = 4;

    typedef struct packed {
        logic [DELAY_W-1:0] delay_samples;
        logic [FB_W-1:0]    feedback_gain;
        logic [MIX_W-1:0]   mix_gain;
        logic               sync_enable;
        logic [DELAY_W-1:0] beat_samples;
        logic [NOTE_W-1:0]  note_division;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        delay_samples: 18'd24000,
        feedback_gain: 15'd16384,
        mix_gain:      16'd16384,
        sync_enable:   1'b0,
        beat_samples:  18'd24000,
        note_division: NOTE_EIGHTH
    };

endpackage

// ----- src/ppd_cfg.sv -----
// Configuration register file of the ping-pong delay block.
module ppd_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [ppd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ppd_pkg::CFG_DATA_W-1:0]   cfg_data,
    output ppd_pkg::cfg_t                    cfg
);

    ppd_pkg::cfg_t cfg_reg;
    ppd_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                ppd_pkg::CFG_DELAY_SAMPLES:
                    cfg_next.delay_samples = cfg_data[ppd_pkg::DELAY_W-1:0];
                ppd_pkg::CFG_FEEDBACK_GAIN:
                    cfg_next.feedback_gain = cfg_data[ppd_pkg::FB_W-1:0];
                ppd_pkg::CFG_MIX_GAIN:
                    cfg_next.mix_gain = cfg_data[ppd_pkg::MIX_W-1:0];
                ppd_pkg::CFG_SYNC_ENABLE:
                    cfg_next.sync_enable = cfg_data[0];
                ppd_pkg::CFG_BEAT_SAMPLES:
                    cfg_next.beat_samples = cfg_data[ppd_pkg::DELAY_W-1:0];
                ppd_pkg::CFG_NOTE_DIVISION:
                    cfg_next.note_division = cfg_data[ppd_pkg::NOTE_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= ppd_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- src/ppd_front.sv -----
// Front end: accepts sample words, works out the delay and the store addresses.
module ppd_front #(
    parameter int BUFFER_DEPTH = 262144,
    parameter int SAMPLE_BITS  = 24,
    parameter int ADDR_BITS    = $clog2(BUFFER_DEPTH)
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  ppd_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] in_left,
    input  logic signed [SAMPLE_BITS-1:0] in_right,
    output logic                          push_valid,
    input  logic                          push_ready,
    output logic signed [SAMPLE_BITS-1:0] push_left,
    output logic signed [SAMPLE_BITS-1:0] push_right,
    output logic [ADDR_BITS-1:0]          push_wp,
    output logic [ADDR_BITS-1:0]          push_rd,
    output logic                          push_rd_ok
);

    localparam int DW     = ppd_pkg::DELAY_W;
    localparam int PROD_W = DW + ppd_pkg::DIV3_MULT_W;
    localparam int CW     = (ADDR_BITS > DW) ? ADDR_BITS : DW;
    localparam logic [CW-1:0]        MAX_DELAY = CW'(BUFFER_DEPTH - 1);
    localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(BUFFER_DEPTH - 1);
    localparam logic [ADDR_BITS-1:0] DEPTH_A   = ADDR_BITS'(BUFFER_DEPTH);

    logic                          a_valid_reg;
    logic                          a_valid_next;
    logic signed [SAMPLE_BITS-1:0] a_left_reg;
    logic signed [SAMPLE_BITS-1:0] a_right_reg;
    logic [PROD_W-1:0]             a_prod_reg;
    logic [ADDR_BITS-1:0]          wp_reg;
    logic [ADDR_BITS-1:0]          wp_next;
    logic                          wrapped_reg;
    logic                          wrapped_next;

    logic                 accept;
    logic                 advance;
    logic [DW-1:0]        base3;
    logic [DW-1:0]        q3;
    logic [DW-1:0]        sync_d;
    logic [DW-1:0]        raw_d;
    logic [CW-1:0]        raw_ext;
    logic [CW-1:0]        clamp_d;
    logic [ADDR_BITS-1:0] d;
    logic [ADDR_BITS:0]   diff;

    assign accept   = in_valid && in_ready;
    assign advance  = a_valid_reg && push_ready;
    assign in_ready = !a_valid_reg || push_ready;

    // The sixteenth triplet divides by six: halve first, then divide by three.
    assign base3 = (cfg.note_division == ppd_pkg::NOTE_SIXTEENTH_TRIPLET) ?
                   (cfg.beat_samples >> 1) : cfg.beat_samples;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (accept)
        begin
            a_valid_next = 1'b1;
        end
        else if (advance)
        begin
            a_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_left_reg  <= in_left;
            a_right_reg <= in_right;
            a_prod_reg  <= PROD_W'(base3) * PROD_W'(ppd_pkg::DIV3_MULT);
        end
    end

    assign q3 = a_prod_reg[ppd_pkg::DIV3_SHIFT +: DW];

    always_comb
    begin
        case (cfg.note_division)
            ppd_pkg::NOTE_EIGHTH:            sync_d = cfg.beat_samples >> 1;
            ppd_pkg::NOTE_EIGHTH_TRIPLET:    sync_d = q3;
            ppd_pkg::NOTE_SIXTEENTH:         sync_d = cfg.beat_samples >> 2;
            ppd_pkg::NOTE_SIXTEENTH_TRIPLET: sync_d = q3;
            default:                         sync_d = cfg.beat_samples;
        endcase
    end

    assign raw_d   = cfg.sync_enable ? sync_d : cfg.delay_samples;
    assign raw_ext = CW'(raw_d);
    assign clamp_d = (raw_ext > MAX_DELAY) ? MAX_DELAY : raw_ext;
    assign d       = clamp_d[ADDR_BITS-1:0];

    assign diff = {1'b0, wp_reg} - {1'b0, d};

    // Until the pointer has wrapped once, only addresses below it hold data.
    assign push_valid = a_valid_reg;
    assign push_left  = a_left_reg;
    assign push_right = a_right_reg;
    assign push_wp    = wp_reg;
    assign push_rd    = diff[ADDR_BITS] ? (diff[ADDR_BITS-1:0] + DEPTH_A)
                                        : diff[ADDR_BITS-1:0];
    assign push_rd_ok = wrapped_reg || (!diff[ADDR_BITS] && (d != '0));

    always_comb
    begin
        wp_next      = wp_reg;
        wrapped_next = wrapped_reg;
        if (advance)
        begin
            if (wp_reg == LAST_ADDR)
            begin
                wp_next      = '0;
                wrapped_next = 1'b1;
            end
            else
            begin
                wp_next = wp_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            wp_reg      <= '0;
            wrapped_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            wp_reg      <= wp_next;
            wrapped_reg <= wrapped_next;
        end
    end

endmodule

// ----- src/ppd_queue.sv -----
// Short first-in first-out queue between the front and back ends.
module ppd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [NW-1:0]    count_reg;
    logic [NW-1:0]    count_next;

    logic push;
    logic pop;

    assign push_ready = (count_reg < NW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- src/ppd_back.sv -----
// Back end: delay store access, gain products, mixing and the output buffer.
module ppd_back #(
    parameter int BUFFER_DEPTH = 262144,
    parameter int SAMPLE_BITS  = 24,
    parameter int ADDR_BITS    = $clog2(BUFFER_DEPTH)
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  ppd_pkg::cfg_t                 cfg,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  logic signed [SAMPLE_BITS-1:0] q_left,
    input  logic signed [SAMPLE_BITS-1:0] q_right,
    input  logic [ADDR_BITS-1:0]          q_wp,
    input  logic [ADDR_BITS-1:0]          q_rd,
    input  logic                          q_rd_ok,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] out_left,
    output logic signed [SAMPLE_BITS-1:0] out_right
);

    localparam int SB    = SAMPLE_BITS;
    localparam int MW    = ppd_pkg::MIX_W;
    localparam int PMW   = SB + MW + 1;
    localparam int PFW   = SB + MW;
    localparam int EW    = SB + 18;
    localparam int OQD   = ppd_pkg::OQ_DEPTH;
    localparam int OQ_AW = $clog2(OQD);
    localparam int OCC_W = $clog2(OQD + 1);
    localparam logic signed [EW-1:0] ROUND_E = EW'(16384);
    localparam logic signed [EW-1:0] SAT_HI  = {{(EW-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [EW-1:0] SAT_LO  = {{(EW-SB+1){1'b1}}, {(SB-1){1'b0}}};

    function automatic logic signed [SB-1:0] saturate(input logic signed [EW-1:0] v);
        logic signed [SB-1:0] r;
        if (v > SAT_HI)
        begin
            r = SAT_HI[SB-1:0];
        end
        else if (v < SAT_LO)
        begin
            r = SAT_LO[SB-1:0];
        end
        else
        begin
            r = v[SB-1:0];
        end
        return r;
    endfunction

    logic signed [SB-1:0] left_mem  [BUFFER_DEPTH];
    logic signed [SB-1:0] right_mem [BUFFER_DEPTH];
    logic signed [SB-1:0] left_q_reg;
    logic signed [SB-1:0] right_q_reg;

    // Read stage results.
    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic signed [SB-1:0] m_left_reg;
    logic signed [SB-1:0] m_right_reg;
    logic [ADDR_BITS-1:0] m_wp_reg;
    logic                 m_rd_ok_reg;
    logic                 m_fwd_reg;
    logic signed [SB-1:0] m_fwd_left_reg;
    logic signed [SB-1:0] m_fwd_right_reg;

    // Product stage results.
    logic                  w_valid_reg;
    logic                  w_valid_next;
    logic signed [SB-1:0]  w_left_reg;
    logic [ADDR_BITS-1:0]  w_wp_reg;
    logic signed [PMW-1:0] w_pxl_reg;
    logic signed [PMW-1:0] w_pdl_reg;
    logic signed [PMW-1:0] w_pxr_reg;
    logic signed [PMW-1:0] w_pdr_reg;
    logic signed [PFW-1:0] w_pfl_reg;
    logic signed [PFW-1:0] w_pfr_reg;

    // Output buffer and the count of words started but not yet taken.
    logic signed [SB-1:0] oq_left_reg  [OQD];
    logic signed [SB-1:0] oq_right_reg [OQD];
    logic [OQ_AW-1:0]     oq_wr_reg;
    logic [OQ_AW-1:0]     oq_wr_next;
    logic [OQ_AW-1:0]     oq_rd_reg;
    logic [OQ_AW-1:0]     oq_rd_next;
    logic [OCC_W-1:0]     oq_count_reg;
    logic [OCC_W-1:0]     oq_count_next;
    logic [OCC_W-1:0]     occ_reg;
    logic [OCC_W-1:0]     occ_next;

    logic                 start;
    logic                 pop;
    logic                 fwd_hit;
    logic signed [SB-1:0] d_left;
    logic signed [SB-1:0] d_right;
    logic [MW-1:0]        mix_c;
    logic [MW-1:0]        dry;
    logic signed [MW:0]   mix_s;
    logic signed [MW:0]   dry_s;
    logic signed [MW:0]   fb_s;
    logic signed [EW-1:0] sum_l;
    logic signed [EW-1:0] sum_r;
    logic signed [EW-1:0] fb_l;
    logic signed [EW-1:0] fb_r;
    logic signed [EW-1:0] st_left_e;
    logic signed [SB-1:0] st_left;
    logic signed [SB-1:0] st_right;
    logic signed [SB-1:0] mix_left;
    logic signed [SB-1:0] mix_right;

    // A word cannot start while the previous one is in its read stage, so a store write can land
    // in the same cycle as the next read; that clash is forwarded.
    assign start   = q_valid && !m_valid_reg && (occ_reg < OCC_W'(OQD));
    assign q_ready = start;
    assign pop     = out_valid && out_ready;
    assign fwd_hit = w_valid_reg && (q_rd == w_wp_reg);

    always_ff @(posedge clk)
    begin
        if (w_valid_reg)
        begin
            left_mem[w_wp_reg] <= st_left;
        end
        if (start)
        begin
            left_q_reg <= left_mem[q_rd];
        end
    end

    always_ff @(posedge clk)
    begin
        if (w_valid_reg)
        begin
            right_mem[w_wp_reg] <= st_right;
        end
        if (start)
        begin
            right_q_reg <= right_mem[q_rd];
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            m_left_reg      <= q_left;
            m_right_reg     <= q_right;
            m_wp_reg        <= q_wp;
            m_rd_ok_reg     <= q_rd_ok;
            m_fwd_reg       <= fwd_hit;
            m_fwd_left_reg  <= st_left;
            m_fwd_right_reg <= st_right;
        end
    end

    // Entries never written since reset read as silence.
    always_comb
    begin
        if (!m_rd_ok_reg)
        begin
            d_left  = '0;
            d_right = '0;
        end
        else if (m_fwd_reg)
        begin
            d_left  = m_fwd_left_reg;
            d_right = m_fwd_right_reg;
        end
        else
        begin
            d_left  = left_q_reg;
            d_right = right_q_reg;
        end
    end

    assign mix_c = (cfg.mix_gain > ppd_pkg::Q15_ONE) ? ppd_pkg::Q15_ONE : cfg.mix_gain;
    assign dry   = ppd_pkg::Q15_ONE - mix_c;
    assign mix_s = $signed({1'b0, mix_c});
    assign dry_s = $signed({1'b0, dry});
    assign fb_s  = $signed({2'b00, cfg.feedback_gain});

    always_ff @(posedge clk)
    begin
        if (m_valid_reg)
        begin
            w_left_reg <= m_left_reg;
            w_wp_reg   <= m_wp_reg;
            w_pxl_reg  <= PMW'(m_left_reg) * PMW'(dry_s);
            w_pdl_reg  <= PMW'(d_left) * PMW'(mix_s);
            w_pxr_reg  <= PMW'(m_right_reg) * PMW'(dry_s);
            w_pdr_reg  <= PMW'(d_right) * PMW'(mix_s);
            w_pfl_reg  <= PFW'(d_right) * PFW'(fb_s);
            w_pfr_reg  <= PFW'(d_left) * PFW'(fb_s);
        end
    end

    // Round half up to Q.15 with an arithmetic shift, then saturate.
    assign sum_l     = (EW'(w_pxl_reg) + EW'(w_pdl_reg) + ROUND_E) >>> 15;
    assign sum_r     = (EW'(w_pxr_reg) + EW'(w_pdr_reg) + ROUND_E) >>> 15;
    assign fb_l      = (EW'(w_pfl_reg) + ROUND_E) >>> 15;
    assign fb_r      = (EW'(w_pfr_reg) + ROUND_E) >>> 15;
    assign st_left_e = fb_l + EW'(w_left_reg);
    assign st_left   = saturate(st_left_e);
    assign st_right  = saturate(fb_r);
    assign mix_left  = saturate(sum_l);
    assign mix_right = saturate(sum_r);

    always_ff @(posedge clk)
    begin
        if (w_valid_reg)
        begin
            oq_left_reg[oq_wr_reg]  <= mix_left;
            oq_right_reg[oq_wr_reg] <= mix_right;
        end
    end

    assign out_valid = (oq_count_reg != '0);
    assign out_left  = oq_left_reg[oq_rd_reg];
    assign out_right = oq_right_reg[oq_rd_reg];

    always_comb
    begin
        m_valid_next  = start;
        w_valid_next  = m_valid_reg;
        oq_wr_next    = oq_wr_reg;
        oq_rd_next    = oq_rd_reg;
        oq_count_next = oq_count_reg;
        occ_next      = occ_reg;
        if (w_valid_reg)
        begin
            oq_wr_next = (oq_wr_reg == OQ_AW'(OQD - 1)) ? '0 : oq_wr_reg + 1'b1;
        end
        if (pop)
        begin
            oq_rd_next = (oq_rd_reg == OQ_AW'(OQD - 1)) ? '0 : oq_rd_reg + 1'b1;
        end
        if (w_valid_reg && !pop)
        begin
            oq_count_next = oq_count_reg + 1'b1;
        end
        else if (pop && !w_valid_reg)
        begin
            oq_count_next = oq_count_reg - 1'b1;
        end
        if (start && !pop)
        begin
            occ_next = occ_reg + 1'b1;
        end
        else if (pop && !start)
        begin
            occ_next = occ_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg  <= 1'b0;
            w_valid_reg  <= 1'b0;
            oq_wr_reg    <= '0;
            oq_rd_reg    <= '0;
            oq_count_reg <= '0;
            occ_reg      <= '0;
        end
        else
        begin
            m_valid_reg  <= m_valid_next;
            w_valid_reg  <= w_valid_next;
            oq_wr_reg    <= oq_wr_next;
            oq_rd_reg    <= oq_rd_next;
            oq_count_reg <= oq_count_next;
            occ_reg      <= occ_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) m_valid_reg |-> !start)
        else $error("word started while the previous one is still in its read stage");

    assert property (@(posedge clk) disable iff (!rst_n) w_valid_reg |-> !m_valid_reg)
        else $error("two words in the product and write stages at once");

    assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg <= OCC_W'(OQD)) && (oq_count_reg <= occ_reg))
        else $error("output buffer credit count out of step");

endmodule

// ----- src/ping_pong_delay_unit.sv -----
// Top level of the stereo ping-pong feedback delay.
// A word passes the input stage, the queue, the store read, the products, and the mix
// and write into the output buffer. The back end takes no new word while the previous
// one is in its read stage, for the read and write of the two delay stores, nor while
// the output buffer has no entry free for it; a queue and an output buffer part the two sides.
// Reset: no clearing pass; a wrap flag beside the write pointer makes store
// entries not yet written read as zero, so words are accepted straight after reset.
module ping_pong_delay_unit #(
    parameter int BUFFER_DEPTH = 262144,
    parameter int SAMPLE_BITS  = 24
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [ppd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ppd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [SAMPLE_BITS-1:0]   in_left,
    input  logic signed [SAMPLE_BITS-1:0]   in_right,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [SAMPLE_BITS-1:0]   out_left,
    output logic signed [SAMPLE_BITS-1:0]   out_right
);

    localparam int AW  = $clog2(BUFFER_DEPTH);
    localparam int QW  = 2 * SAMPLE_BITS + 2 * AW + 1;

    ppd_pkg::cfg_t cfg;

    logic                          push_valid;
    logic                          push_ready;
    logic signed [SAMPLE_BITS-1:0] push_left;
    logic signed [SAMPLE_BITS-1:0] push_right;
    logic [AW-1:0]                 push_wp;
    logic [AW-1:0]                 push_rd;
    logic                          push_rd_ok;
    logic [QW-1:0]                 push_data;
    logic                          pop_valid;
    logic                          pop_ready;
    logic [QW-1:0]                 pop_data;

    ppd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ppd_front #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .ADDR_BITS    (AW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_left    (in_left),
        .in_right   (in_right),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_left  (push_left),
        .push_right (push_right),
        .push_wp    (push_wp),
        .push_rd    (push_rd),
        .push_rd_ok (push_rd_ok)
    );

    assign push_data = {push_left, push_right, push_wp, push_rd, push_rd_ok};

    ppd_queue #(
        .WIDTH (QW),
        .DEPTH (ppd_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    ppd_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .ADDR_BITS    (AW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (pop_valid),
        .q_ready   (pop_ready),
        .q_left    (pop_data[QW-1 -: SAMPLE_BITS]),
        .q_right   (pop_data[2*AW+SAMPLE_BITS -: SAMPLE_BITS]),
        .q_wp      (pop_data[2*AW -: AW]),
        .q_rd      (pop_data[AW -: AW]),
        .q_rd_ok   (pop_data[0]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_left  (out_left),
        .out_right (out_right)
    );

endmodule
